### rtl/akwq_pkg.sv
// ---------------------------------------------------------------------------
// akwq_pkg
// Shared widths and codes for the address-keyed wait queue.
// ---------------------------------------------------------------------------
package akwq_pkg;

	localparam int DEF_MAX_THREADS = 16;

	localparam int CMD_W    = 2;
	localparam int THREAD_W = 4;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WAIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WAKE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LEAVE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ENQUEUED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FAULT       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WOKEN       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_WAKE_DONE   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_LEFT        = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_QUEUED  = 3'd6;

endpackage

### rtl/address_keyed_wait_queue_unit.sv
// ---------------------------------------------------------------------------
// address_keyed_wait_queue_unit
// Futex-style wait queue: FIFO of waiting threads keyed by address.
// ---------------------------------------------------------------------------
// Channel  Handshake           Payload
// in       in_valid/in_stall   cmd thread_id wait_address expected_value
//                              memory_word address_fault wake_limit
// out      out_valid/out_stall status woken_thread wake_total last
//
// Fault, would-block and not-queued answer in the cycle after the transfer.
// A wait or leave on a queued thread, and a wake with a nonzero limit, run one
// compacting pass over the queue memory: one slot read per cycle, paced by the
// single order-memory read port.
// No clearing pass after reset; queue length and waiting flags reset to zero.
// A stalled output freezes the whole pass; input stays stalled until the
// last result of a command is loaded.
// ---------------------------------------------------------------------------
module address_keyed_wait_queue_unit
	import akwq_pkg::*;
#(
	parameter int MAX_THREADS = DEF_MAX_THREADS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [THREAD_W-1:0] thread_id,
	input  logic [ADDR_W-1:0]   wait_address,
	input  logic [ADDR_W-1:0]   expected_value,
	input  logic [ADDR_W-1:0]   memory_word,
	input  logic                address_fault,
	input  logic [ADDR_W-1:0]   wake_limit,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [THREAD_W-1:0] woken_thread,
	output logic [COUNT_W-1:0]  wake_total,
	output logic                last
);

	localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int LEN_W = $clog2(MAX_THREADS + 1);

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t state_q;

	logic [THREAD_W-1:0] order_mem [MAX_THREADS];
	logic [ADDR_W-1:0]   addr_mem  [MAX_THREADS];

	logic [MAX_THREADS-1:0] flag_q;
	logic [LEN_W-1:0]       len_q, r_q, w_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [THREAD_W-1:0]    tid_q;
	logic [ADDR_W-1:0]      addr_q, limit_q;
	logic [COUNT_W-1:0]     cnt_q;

	logic                v_s2, v_s3, flag_s3;
	logic [THREAD_W-1:0] ord_rd_s2, t_s3;
	logic [ADDR_W-1:0]   addr_rd_s3;

	logic                out_valid_q, last_q;
	logic [STATUS_W-1:0] status_q;
	logic [THREAD_W-1:0] woken_q;
	logic [COUNT_W-1:0]  count_q;

	logic             adv, issue, drop_s3, done, tid_ok, appending;
	logic             ord_we, addr_we;
	logic [IDX_W-1:0] tidx_in, tidx_q, ord_wa;
	logic [THREAD_W-1:0] ord_wd;

	// everything moves only when the output register can take a result
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && adv);
	assign tidx_in  = IDX_W'(thread_id);
	assign tidx_q   = IDX_W'(tid_q);
	assign tid_ok   = (32'(thread_id) < MAX_THREADS);

	assign issue = (state_q == S_SCAN) && adv && (r_q != len_q);
	assign done  = (state_q == S_SCAN) && !v_s2 && !v_s3 && (r_q == len_q);

	// a slot leaves the queue: a woken match, or the thread being unqueued
	assign drop_s3 = v_s3 && flag_s3 &&
		((cmd_q == CMD_WAKE) ? ((addr_rd_s3 == addr_q) && (limit_q != '0))
		                     : (t_s3 == tid_q));

	assign appending = (cmd_q == CMD_WAIT) && (w_q != LEN_W'(MAX_THREADS));

	assign ord_we  = adv && ((v_s3 && !drop_s3) || (done && appending));
	assign ord_wa  = w_q[IDX_W-1:0];
	assign ord_wd  = v_s3 ? t_s3 : tid_q;
	assign addr_we = adv && done && appending;

	// order memory: kept slots are written back compacted, w_q <= r_q
	always_ff @(posedge clk) begin
		if (ord_we)
			order_mem[ord_wa] <= ord_wd;
		if (issue)
			ord_rd_s2 <= order_mem[r_q[IDX_W-1:0]];
	end

	// address memory: written on append, read by thread in the second stage
	always_ff @(posedge clk) begin
		if (addr_we)
			addr_mem[tidx_q] <= addr_q;
		if (adv && v_s2)
			addr_rd_s3 <= addr_mem[IDX_W'(ord_rd_s2)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			flag_q      <= '0;
			len_q       <= '0;
			r_q         <= '0;
			w_q         <= '0;
			cmd_q       <= CMD_WAIT;
			tid_q       <= '0;
			addr_q      <= '0;
			limit_q     <= '0;
			cnt_q       <= '0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			flag_s3     <= 1'b0;
			t_s3        <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_ENQUEUED;
			woken_q     <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b0;
			woken_q     <= '0;
			count_q     <= '0;
			last_q      <= 1'b1;

			v_s2 <= issue;
			if (issue)
				r_q <= r_q + LEN_W'(1);

			v_s3 <= v_s2;
			t_s3 <= ord_rd_s2;
			if (v_s2)
				flag_s3 <= flag_q[IDX_W'(ord_rd_s2)];

			if (v_s3) begin
				if (drop_s3) begin
					flag_q[IDX_W'(t_s3)] <= 1'b0;
					if (cmd_q == CMD_WAKE) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_WOKEN;
						woken_q     <= t_s3;
						last_q      <= 1'b0;
						limit_q     <= limit_q - 32'd1;
						cnt_q       <= cnt_q + COUNT_W'(1);
					end
				end else begin
					w_q <= w_q + LEN_W'(1);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						tid_q   <= thread_id;
						addr_q  <= wait_address;
						limit_q <= wake_limit;
						cnt_q   <= '0;
						case (cmd)
							CMD_WAIT: begin
								if (address_fault || !tid_ok) begin
									out_valid_q <= 1'b1;
									status_q    <= ST_FAULT;
								end else if (memory_word != expected_value) begin
									out_valid_q <= 1'b1;
									status_q    <= ST_WOULD_BLOCK;
								end else begin
									state_q <= S_SCAN;
									r_q     <= flag_q[tidx_in] ? '0 : len_q;
									w_q     <= flag_q[tidx_in] ? '0 : len_q;
								end
							end
							CMD_WAKE: begin
								state_q <= S_SCAN;
								r_q     <= (wake_limit != '0) ? '0 : len_q;
								w_q     <= (wake_limit != '0) ? '0 : len_q;
							end
							CMD_LEAVE: begin
								if (tid_ok && flag_q[tidx_in]) begin
									state_q <= S_SCAN;
									r_q     <= '0;
									w_q     <= '0;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= ST_NOT_QUEUED;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (done) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						len_q       <= appending ? (w_q + LEN_W'(1)) : w_q;
						if (appending)
							flag_q[tidx_q] <= 1'b1;
						case (cmd_q)
							CMD_WAIT:  status_q <= ST_ENQUEUED;
							CMD_WAKE: begin
								status_q <= ST_WAKE_DONE;
								count_q  <= cnt_q;
							end
							default:   status_q <= ST_LEFT;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign woken_thread = woken_q;
	assign wake_total   = count_q;
	assign last         = last_q;

endmodule

### rtl/akwq_checker.sv
// ---------------------------------------------------------------------------
// akwq_checker
// Port-level checks for the address-keyed wait queue, bound to the top level.
// ---------------------------------------------------------------------------
module akwq_checker
	import akwq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [CMD_W-1:0]    cmd,
	input logic                address_fault,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic                last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
		else $error("stalled result changed");

	// no new command while a multi-result command is still running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken during wake results");

	// a faulting wait answers on the next cycle
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_WAIT) && address_fault
		|=> out_valid && (status == ST_FAULT) && last)
		else $error("fault not reported");

	// only woken-thread results are non-final
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_WOKEN) != last))
		else $error("last flag inconsistent with status");

endmodule

bind address_keyed_wait_queue_unit akwq_checker u_akwq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.cmd           (cmd),
	.address_fault (address_fault),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.last          (last)
);

### sim/address_keyed_wait_queue_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// address_keyed_wait_queue_unit_tb
// Self-checking bench for the futex-style wait queue. A short directed pass
// covers faults, would-block, requeue, zero and unbounded wake limits and
// leave; random wait/wake/leave traffic and fill-then-wake runs, some up to a
// full queue, follow, with bursty input and patterned output stalls. Each
// result is checked against a behavioral copy of the waiter queue.
// ---------------------------------------------------------------------------
module address_keyed_wait_queue_unit_tb;
	import akwq_pkg::*;

	localparam int MAX_THREADS    = DEF_MAX_THREADS;
	localparam int CLK_PERIOD     = 12;
	localparam int TOTAL_ITEMS    = 500;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 40;
	localparam int TIMEOUT_CYCLES = 1_000_000;

	// reserved command code, dropped by the block
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_t;

	typedef struct {
		logic [CMD_W-1:0]    op;
		logic [THREAD_W-1:0] thread;
		logic [ADDR_W-1:0]   addr;
		logic [ADDR_W-1:0]   expect_word;
		logic [ADDR_W-1:0]   mem_word;
		logic                fault;
		logic [ADDR_W-1:0]   limit;
	} waitq_cmd_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [THREAD_W-1:0] thread;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} waitq_result_t;

	// Waiter queue model plus the results still owed by the block.
	class waitq_tracker;
		logic [THREAD_W-1:0] arrival_order[$];
		logic [ADDR_W-1:0]   parked_addr[MAX_THREADS];
		bit                  parked[MAX_THREADS];
		waitq_result_t       due_results[$];
		int                  errors;

		function void queue_result(logic [STATUS_W-1:0] st, logic [THREAD_W-1:0] thr,
			logic [COUNT_W-1:0] cnt, logic fin);
			waitq_result_t r;
			r.status = st;
			r.thread = thr;
			r.count  = cnt;
			r.last   = fin;
			due_results.push_back(r);
		endfunction

		// pull a thread out of the queue, keeping arrival order; 1 if it was parked
		function bit unpark(logic [THREAD_W-1:0] t);
			if (!parked[t])
				return 1'b0;
			for (int i = 0; i < arrival_order.size(); i++) begin
				if (arrival_order[i] == t) begin
					arrival_order.delete(i);
					break;
				end
			end
			parked[t] = 1'b0;
			return 1'b1;
		endfunction

		function void note_command(waitq_cmd_t c);
			logic [ADDR_W-1:0]   budget;
			logic [COUNT_W-1:0]  woken;
			logic [THREAD_W-1:0] t;
			int                  i;
			case (c.op)
				CMD_WAIT: begin
					// fault wins over a value mismatch
					if (c.fault)
						queue_result(ST_FAULT, '0, '0, 1'b1);
					else if (c.mem_word != c.expect_word)
						queue_result(ST_WOULD_BLOCK, '0, '0, 1'b1);
					else begin
						void'(unpark(c.thread));
						arrival_order.push_back(c.thread);
						parked_addr[c.thread] = c.addr;
						parked[c.thread] = 1'b1;
						queue_result(ST_ENQUEUED, '0, '0, 1'b1);
					end
				end
				CMD_WAKE: begin
					budget = c.limit;
					woken  = '0;
					i      = 0;
					while (budget != 0 && i < arrival_order.size()) begin
						t = arrival_order[i];
						if (parked[t] && parked_addr[t] == c.addr) begin
							arrival_order.delete(i);
							parked[t] = 1'b0;
							queue_result(ST_WOKEN, t, '0, 1'b0);
							woken++;
							budget--;
						end else begin
							i++;
						end
					end
					queue_result(ST_WAKE_DONE, '0, woken, 1'b1);
				end
				CMD_LEAVE: begin
					if (unpark(c.thread))
						queue_result(ST_LEFT, '0, '0, 1'b1);
					else
						queue_result(ST_NOT_QUEUED, '0, '0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [THREAD_W-1:0] thr,
			logic [COUNT_W-1:0] cnt, logic fin);
			waitq_result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d thread %0d count %0d last %0d",
					st, thr, cnt, fin);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare("status", 32'(want.status), 32'(st));
			compare("woken_thread", 32'(want.thread), 32'(thr));
			compare("wake_total", 32'(want.count), 32'(cnt));
			compare("last", 32'(want.last), 32'(fin));
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd;
	logic [THREAD_W-1:0] thread_id;
	logic [ADDR_W-1:0]   wait_address;
	logic [ADDR_W-1:0]   expected_value;
	logic [ADDR_W-1:0]   memory_word;
	logic                address_fault;
	logic [ADDR_W-1:0]   wake_limit;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [THREAD_W-1:0] woken_thread;
	logic [COUNT_W-1:0]  wake_total;
	logic                last;

	waitq_tracker tracker = new;
	int           sent_items = 0;
	int           burst_left = 0;
	bit           hold_request = 1'b0;

	address_keyed_wait_queue_unit dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(status, woken_thread, wake_total, last);
	end

	// receiver: changes stall mode every so often; a long hold on request
	initial begin
		rx_mode_t   mode;
		int         mode_left;
		logic [7:0] pattern;
		mode      = RX_READY;
		mode_left = 0;
		pattern   = 8'h5A;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 200);
					pattern   = 8'($urandom());
				end
				mode_left--;
				case (mode)
					RX_READY: out_stall <= 1'b0;
					RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
					default: begin
						out_stall <= pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
				endcase
			end
		end
	end

	// Called right after a rising edge; returns right after the transfer edge
	// or after the idle gap that follows it.
	task automatic send_cmd(waitq_cmd_t c);
		int gap;
		cmd            <= c.op;
		thread_id      <= c.thread;
		wait_address   <= c.addr;
		expected_value <= c.expect_word;
		memory_word    <= c.mem_word;
		address_fault  <= c.fault;
		wake_limit     <= c.limit;
		in_valid       <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_command(c);
		if (c.op != CMD_UNUSED)
			sent_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic waitq_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [THREAD_W-1:0] thr,
		logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] exp_word, logic [ADDR_W-1:0] word,
		logic fault, logic [ADDR_W-1:0] limit);
		waitq_cmd_t c;
		c.op          = op;
		c.thread      = thr;
		c.addr        = addr;
		c.expect_word = exp_word;
		c.mem_word    = word;
		c.fault       = fault;
		c.limit       = limit;
		return c;
	endfunction

	// a few hot addresses so wakes find matches, plus fully random ones
	function automatic logic [ADDR_W-1:0] pick_address();
		case ($urandom_range(0, 9))
			0, 1, 2: return 32'h0000_1000;
			3, 4: return 32'h0000_1040;
			5: return 32'hFFFF_FFFC;
			6: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return '0;
			1, 2: return $urandom_range(1, 3);
			3: return MAX_THREADS;
			4: return 32'hFFFF_FFFF;
			5: return $urandom();
			default: return $urandom_range(1, MAX_THREADS);
		endcase
	endfunction

	function automatic waitq_cmd_t random_cmd();
		waitq_cmd_t c;
		int         pick;
		pick          = $urandom_range(0, 99);
		c.thread      = THREAD_W'($urandom_range(0, MAX_THREADS - 1));
		c.addr        = pick_address();
		c.expect_word = $urandom();
		c.mem_word    = c.expect_word;
		c.fault       = 1'($urandom_range(0, 1));
		c.limit       = pick_limit();
		if (pick < 55) begin
			c.op    = CMD_WAIT;
			c.fault = 1'b0;
			case ($urandom_range(0, 9))
				0: c.fault = 1'b1;
				1: begin
					c.fault    = 1'b1;
					c.mem_word = $urandom();
				end
				2: c.mem_word = c.expect_word ^ (32'h1 << $urandom_range(0, 31));
				3: c.mem_word = $urandom();
				default: ;
			endcase
		end else if (pick < 78) begin
			c.op = CMD_WAKE;
		end else if (pick < 96) begin
			c.op = CMD_LEAVE;
		end else begin
			c.op = CMD_UNUSED;
		end
		return c;
	endfunction

	// park a shuffled set of threads on one address, then wake on it
	task automatic fill_and_wake();
		logic [THREAD_W-1:0] ids[MAX_THREADS];
		logic [THREAD_W-1:0] tmp;
		waitq_cmd_t          c;
		int                  depth;
		int                  j;
		foreach (ids[i])
			ids[i] = THREAD_W'(i);
		for (int i = MAX_THREADS - 1; i > 0; i--) begin
			j      = $urandom_range(0, i);
			tmp    = ids[i];
			ids[i] = ids[j];
			ids[j] = tmp;
		end
		depth = ($urandom_range(0, 3) == 0) ? MAX_THREADS : $urandom_range(2, MAX_THREADS);
		c       = random_cmd();
		c.op    = CMD_WAIT;
		c.fault = 1'b0;
		for (int i = 0; i < depth; i++) begin
			c.thread      = ids[i];
			c.expect_word = $urandom();
			c.mem_word    = c.expect_word;
			send_cmd(c);
		end
		c.op    = CMD_WAKE;
		c.fault = 1'($urandom_range(0, 1));
		c.limit = $urandom_range(0, 1) ? 32'hFFFF_FFFF : pick_limit();
		send_cmd(c);
	endtask

	initial begin
		bit held;
		bit paused;
		held           = 1'b0;
		paused         = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_WAIT;
		thread_id      = '0;
		wait_address   = '0;
		expected_value = '0;
		memory_word    = '0;
		address_fault  = 1'b0;
		wake_limit     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(make_cmd(CMD_WAIT, 4'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0));
		send_cmd(make_cmd(CMD_WAIT, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0));
		send_cmd(make_cmd(CMD_WAIT, 4'd2, 32'h1234, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0,
			32'h0));
		send_cmd(make_cmd(CMD_UNUSED, 4'd3, 32'h0, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF));
		send_cmd(make_cmd(CMD_LEAVE, 4'd3, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0));
		send_cmd(make_cmd(CMD_WAKE, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF));
		send_cmd(make_cmd(CMD_WAIT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, 32'h0));
		send_cmd(make_cmd(CMD_WAIT, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0));
		send_cmd(make_cmd(CMD_WAIT, 4'd5, 32'hFFFF_FFFF, 32'h7, 32'h7, 1'b0, 32'h0));
		// requeue of a parked thread moves it to the tail on the new address
		send_cmd(make_cmd(CMD_WAIT, 4'd15, 32'h0, 32'h9, 32'h9, 1'b0, 32'h0));
		send_cmd(make_cmd(CMD_WAKE, 4'd1, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0));
		send_cmd(make_cmd(CMD_WAKE, 4'd1, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF));
		send_cmd(make_cmd(CMD_WAKE, 4'd2, 32'h0, 32'h0, 32'h0, 1'b0, 32'h1));
		send_cmd(make_cmd(CMD_LEAVE, 4'd5, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0));
		send_cmd(make_cmd(CMD_LEAVE, 4'd5, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0));
		send_cmd(make_cmd(CMD_WAKE, 4'd9, 32'h0, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF));
		send_cmd(make_cmd(CMD_WAKE, 4'd9, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF));

		while (sent_items < TOTAL_ITEMS) begin
			// long output hold while input keeps offering
			if (!held && sent_items > 150) begin
				hold_request = 1'b1;
				held = 1'b1;
			end
			if (!paused && sent_items > 320) begin
				await_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				fill_and_wake();
			else
				send_cmd(random_cmd());
		end

		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
